### rtl/cle_pkg.sv
// shared constants, types and key decode for the cursor line editor
`timescale 1ns / 1ps
package cle_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] KEY_LEFT    = 8'd60;
  localparam logic [CHAR_W-1:0] KEY_RIGHT   = 8'd62;
  localparam logic [CHAR_W-1:0] KEY_DELETE  = 8'd45;
  localparam logic [CHAR_W-1:0] KEY_NEWLINE = 8'd10;

  typedef enum logic [2:0] {
    KIND_INSERT,
    KIND_LEFT,
    KIND_RIGHT,
    KIND_DELETE,
    KIND_NEWLINE
  } key_kind_t;

  // one-hot commands from the controller to the datapath
  typedef struct packed {
    logic take_key;
    logic insert;
    logic delete_char;
    logic rd_left_top;
    logic wr_right;
    logic rd_right_top;
    logic wr_left;
    logic emit_empty;
    logic flush_start;
    logic flush_read;
    logic flush_emit;
  } cmd_t;

  typedef struct packed {
    key_kind_t kind;
    logic      can_left;
    logic      can_right;
    logic      line_empty;
    logic      out_free;
    logic      flush_last;
  } status_t;

  function automatic key_kind_t decode_key(input logic [CHAR_W-1:0] key);
    key_kind_t k;
    case (key)
      KEY_LEFT:    k = KIND_LEFT;
      KEY_RIGHT:   k = KIND_RIGHT;
      KEY_DELETE:  k = KIND_DELETE;
      KEY_NEWLINE: k = KIND_NEWLINE;
      default:     k = KIND_INSERT;
    endcase
    return k;
  endfunction

endpackage

### rtl/cle_datapath.sv
// datapath: the two character stacks, counts, overflow flag and output register
`timescale 1ns / 1ps
module cle_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  cle_pkg::cmd_t            cmd,
  output cle_pkg::status_t         status,
  input  logic [cle_pkg::CHAR_W-1:0] key,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [cle_pkg::CHAR_W-1:0] m_tdata,
  output logic                     m_tlast,
  output logic [1:0]               m_tuser
);
  import cle_pkg::*;

  logic [CHAR_W-1:0] left_mem  [LINE_DEPTH];
  logic [CHAR_W-1:0] right_mem [LINE_DEPTH];

  logic [CHAR_W-1:0] key_reg;
  logic [CHAR_W-1:0] left_q;
  logic [CHAR_W-1:0] right_q;
  logic [CNT_W-1:0]  left_count;
  logic [CNT_W-1:0]  right_count;
  logic [CNT_W-1:0]  idx;
  logic              overflow_seen;
  logic              src_left;

  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  right_pos;
  logic              flush_from_left;
  logic [ADDR_W-1:0] left_rd_addr;
  logic [ADDR_W-1:0] right_rd_addr;
  logic [CNT_W-1:0]  left_top;
  logic [CNT_W-1:0]  right_top;

  assign total           = left_count + right_count;
  assign left_top        = left_count - CNT_W'(1);
  assign right_top       = right_count - CNT_W'(1);
  // right stack is walked from its top down during a flush
  assign right_pos       = total - CNT_W'(1) - idx;
  assign flush_from_left = (idx < left_count);
  assign left_rd_addr    = cmd.flush_read ? idx[ADDR_W-1:0] : left_top[ADDR_W-1:0];
  assign right_rd_addr   = cmd.flush_read ? right_pos[ADDR_W-1:0] : right_top[ADDR_W-1:0];

  assign status.kind       = decode_key(key_reg);
  assign status.can_left   = (left_count != '0) && (right_count < CNT_W'(LINE_DEPTH));
  assign status.can_right  = (right_count != '0) && (left_count < CNT_W'(LINE_DEPTH));
  assign status.line_empty = (total == '0);
  assign status.out_free   = !m_tvalid || m_tready;
  assign status.flush_last = ((idx + CNT_W'(1)) == total);

  // stack memories
  always_ff @(posedge clk) begin
    if (cmd.insert && (total < CNT_W'(LINE_DEPTH))) begin
      left_mem[left_count[ADDR_W-1:0]] <= key_reg;
    end else if (cmd.wr_left) begin
      left_mem[left_count[ADDR_W-1:0]] <= right_q;
    end
    if (cmd.wr_right) begin
      right_mem[right_count[ADDR_W-1:0]] <= left_q;
    end
    if (cmd.rd_left_top || (cmd.flush_read && flush_from_left)) begin
      left_q <= left_mem[left_rd_addr];
    end
    if (cmd.rd_right_top || (cmd.flush_read && !flush_from_left)) begin
      right_q <= right_mem[right_rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_key) begin
      key_reg <= key;
    end
    if (cmd.flush_read) begin
      src_left <= flush_from_left;
    end
    if (cmd.emit_empty) begin
      m_tdata    <= '0;
      m_tlast    <= 1'b1;
      m_tuser[0] <= 1'b1;
      m_tuser[1] <= overflow_seen;
    end else if (cmd.flush_emit) begin
      m_tdata    <= src_left ? left_q : right_q;
      m_tlast    <= status.flush_last;
      m_tuser[0] <= 1'b0;
      m_tuser[1] <= overflow_seen;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count    <= '0;
      right_count   <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cmd.emit_empty || cmd.flush_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cmd.insert) begin
        if (total < CNT_W'(LINE_DEPTH)) begin
          left_count <= left_count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.delete_char && (left_count != '0)) begin
        left_count <= left_top;
      end
      if (cmd.rd_left_top) begin
        left_count <= left_top;
      end
      if (cmd.wr_right) begin
        right_count <= right_count + CNT_W'(1);
      end
      if (cmd.rd_right_top) begin
        right_count <= right_top;
      end
      if (cmd.wr_left) begin
        left_count <= left_count + CNT_W'(1);
      end
      if (cmd.flush_start) begin
        idx <= '0;
      end
      if (cmd.flush_emit) begin
        idx <= idx + CNT_W'(1);
      end
      // line done: both stacks and the overflow flag start afresh
      if (cmd.emit_empty || (cmd.flush_emit && status.flush_last)) begin
        left_count    <= '0;
        right_count   <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

endmodule

### rtl/cle_ctrl.sv
// controller state machine: key dispatch, cursor moves and line flush sequencing
`timescale 1ns / 1ps
module cle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  cle_pkg::status_t status,
  output cle_pkg::cmd_t    cmd
);
  import cle_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOVE_L,
    ST_MOVE_R,
    ST_FL_EMPTY,
    ST_FL_RD,
    ST_FL_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take_key = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (status.kind)
          KIND_INSERT: cmd.insert = 1'b1;
          KIND_DELETE: cmd.delete_char = 1'b1;
          KIND_LEFT: begin
            if (status.can_left) begin
              cmd.rd_left_top = 1'b1;
              state_next      = ST_MOVE_L;
            end
          end
          KIND_RIGHT: begin
            if (status.can_right) begin
              cmd.rd_right_top = 1'b1;
              state_next       = ST_MOVE_R;
            end
          end
          KIND_NEWLINE: begin
            if (status.line_empty) begin
              state_next = ST_FL_EMPTY;
            end else begin
              cmd.flush_start = 1'b1;
              state_next      = ST_FL_RD;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_MOVE_L: begin
        cmd.wr_right = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_MOVE_R: begin
        cmd.wr_left = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_FL_EMPTY: begin
        if (status.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_FL_RD: begin
        cmd.flush_read = 1'b1;
        state_next     = ST_FL_WAIT;
      end
      ST_FL_WAIT: begin
        // hold the read data until the output register can take the beat
        if (status.out_free) begin
          cmd.flush_emit = 1'b1;
          state_next     = status.flush_last ? ST_IDLE : ST_FL_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/cursor_line_editor_top.sv
// an edit key is registered in the idle state, then carried out in the execute state; a cursor move
// adds a registered stack read, then a write to the other stack; the next key is taken only when idle
// a newline flushes the line beat by beat (read, then load of the output register once it is free)
// the output register lets the next key be taken while the final beat of a line waits
// reset (rst, synchronous, high) empties both stacks, clears overflow and the output valid
`timescale 1ns / 1ps
module cursor_line_editor_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // key
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // text_char
  output logic       m_tlast,   // last_of_line
  output logic [1:0] m_tuser    // line_empty, overflowed
);
  import cle_pkg::*;

  cmd_t    cmd;
  status_t status;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cle_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .key      (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### rtl/cle_checker.sv
// port-level checks on the line editor, bound to the top level
`timescale 1ns / 1ps
module cle_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // an empty line is a single closing beat with zero data
  a_empty_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'd0))
    else $error("empty line beat malformed");

  // each key needs an execute state before the next one is taken
  a_key_spacing: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("key taken back to back");

  // nothing leaves the block straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind cursor_line_editor_top cle_checker u_cle_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

### bench/cursor_line_editor_top_test.sv
// self-checking bench for the cursor line editor: random edit keys, line flush checked per beat
`timescale 1ns / 1ps
module cursor_line_editor_top_test;
  import cle_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int KEYS_PER_PHASE = 28;

  typedef struct {
    logic [7:0] text;
    bit         last;
    bit         empty;
    bit         ovf;
  } line_beat_t;

  class line_scoreboard;
    logic [7:0]  left_chars[LINE_DEPTH];
    logic [7:0]  right_chars[LINE_DEPTH];
    int          left_cnt;
    int          right_cnt;
    bit          ovf_seen;
    line_beat_t  expected_beats[$];
    int          errors;

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void push_beat(logic [7:0] text, bit last, bit empty);
      line_beat_t b;
      b.text = text;
      b.last = last;
      b.empty = empty;
      b.ovf = ovf_seen;
      expected_beats.push_back(b);
    endfunction

    // one accepted key: update the two stacks, queue the line on a newline
    function void note_key(logic [7:0] key);
      int total;
      int n;
      case (key)
        KEY_LEFT: begin
          if (left_cnt > 0 && right_cnt < LINE_DEPTH) begin
            left_cnt--;
            right_chars[right_cnt] = left_chars[left_cnt];
            right_cnt++;
          end
        end
        KEY_RIGHT: begin
          if (right_cnt > 0 && left_cnt < LINE_DEPTH) begin
            right_cnt--;
            left_chars[left_cnt] = right_chars[right_cnt];
            left_cnt++;
          end
        end
        KEY_DELETE: begin
          if (left_cnt > 0) left_cnt--;
        end
        KEY_NEWLINE: begin
          total = left_cnt + right_cnt;
          n = 0;
          if (total == 0) begin
            push_beat(8'h00, 1'b1, 1'b1);
          end else begin
            for (int i = 0; i < left_cnt; i++) begin
              push_beat(left_chars[i], n + 1 == total, 1'b0);
              n++;
            end
            for (int i = right_cnt - 1; i >= 0; i--) begin
              push_beat(right_chars[i], n + 1 == total, 1'b0);
              n++;
            end
          end
          left_cnt = 0;
          right_cnt = 0;
          ovf_seen = 1'b0;
        end
        default: begin
          if (left_cnt + right_cnt >= LINE_DEPTH) begin
            ovf_seen = 1'b1;
          end else begin
            left_chars[left_cnt] = key;
            left_cnt++;
          end
        end
      endcase
    endfunction

    function void check_beat(logic [7:0] text, logic last, logic [1:0] user);
      line_beat_t b;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat text=%02h last=%0b user=%02b", text, last, user));
        return;
      end
      b = expected_beats.pop_front();
      if (last !== b.last)
        report($sformatf("last got %0b want %0b", last, b.last));
      if (user[0] !== b.empty)
        report($sformatf("line_empty got %0b want %0b", user[0], b.empty));
      if (user[1] !== b.ovf)
        report($sformatf("overflowed got %0b want %0b", user[1], b.ovf));
      // text is meaningless on an empty line
      if (!b.empty && text !== b.text)
        report($sformatf("text got %02h want %02h", text, b.text));
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void drain_check();
      if (expected_beats.size() != 0)
        report($sformatf("%0d beats never arrived", expected_beats.size()));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  logic       hold_start = 1'b0;
  int         hold_left = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         keys_sent = 0;
  int         cycles = 0;

  line_scoreboard sb;

  cursor_line_editor_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check each beat, stall at random or hold off for a long stretch
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_beat(m_tdata, m_tlast, m_tuser);
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_key(input logic [7:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= key;
    do @(posedge clk); while (!s_tready);
    sb.note_key(key);
    keys_sent++;
  endtask

  function automatic logic [7:0] pick_key(int insert_pct);
    int r;
    logic [7:0] k;
    r = $urandom_range(99);
    if (r < insert_pct) begin
      k = 8'($urandom_range(255));
      while (k == KEY_NEWLINE) k = 8'($urandom_range(255));
      return k;
    end
    r = $urandom_range(9);
    if (r < 4) return KEY_LEFT;
    if (r < 8) return KEY_RIGHT;
    return KEY_DELETE;
  endfunction

  task automatic send_line(input int n_edits, input int insert_pct);
    for (int i = 0; i < n_edits; i++) send_key(pick_key(insert_pct));
    send_key(KEY_NEWLINE);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random lines, mostly short, now and then one long enough to fill up
  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = keys_sent + KEYS_PER_PHASE;
    while (keys_sent < target) begin
      if ($urandom_range(11) == 0)
        send_line($urandom_range(60, 80), 90);
      else if ($urandom_range(7) == 0)
        send_line($urandom_range(0, 4), 0);
      else
        send_line($urandom_range(0, 14), 60);
    end
    settle();
  endtask

  initial begin
    sb = new;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edits on an empty line are ignored, then the empty line itself
    send_key(KEY_LEFT);
    send_key(KEY_RIGHT);
    send_key(KEY_DELETE);
    send_key(KEY_NEWLINE);
    // extremes of the byte, cursor moves both ways, delete mid-line
    send_key(8'h00);
    send_key(8'hFF);
    send_key(8'h41);
    send_key(KEY_LEFT);
    send_key(KEY_LEFT);
    send_key(8'h7E);
    send_key(KEY_DELETE);
    send_key(KEY_RIGHT);
    send_key(KEY_DELETE);
    send_key(KEY_RIGHT);
    send_key(KEY_RIGHT);
    send_key(8'h0B);
    send_key(KEY_LEFT);
    send_key(KEY_NEWLINE);
    send_key(KEY_NEWLINE);
    settle();

    // full line with the cursor moved into it, then overflow on a line deleted to nothing
    for (int i = 0; i < LINE_DEPTH + 2; i++) send_key(8'($urandom_range(11, 44)));
    for (int i = 0; i < 10; i++) send_key(KEY_LEFT);
    send_key(KEY_NEWLINE);
    for (int i = 0; i < LINE_DEPTH + 1; i++) send_key(8'($urandom_range(11, 44)));
    for (int i = 0; i < LINE_DEPTH; i++) send_key(KEY_DELETE);
    send_key(KEY_NEWLINE);
    settle();

    run_phase(0, 0);

    // long hold-off on the result side while keys keep coming
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_line(40, 95);
    run_phase(50, 0);

    run_phase(0, 50);
    run_phase(24, 24);

    settle();
    sb.drain_check();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/cle_pkg.sv
rtl/cle_datapath.sv
rtl/cle_ctrl.sv
rtl/cursor_line_editor_top.sv
rtl/cle_checker.sv
bench/cursor_line_editor_top_test.sv
